// File: src/tlc_pkg.sv
// Shared types, status codes and a helper function for the two-level tag lookup.
package tlc_pkg;

    localparam int SET_W   = 16;
    localparam int TAG_W   = 32;
    localparam int WCNT_W  = 7;

    localparam logic [2:0] REG_L1_OFF  = 3'd0;
    localparam logic [2:0] REG_L1_IDX  = 3'd1;
    localparam logic [2:0] REG_L1_WAYS = 3'd2;
    localparam logic [2:0] REG_L2_OFF  = 3'd3;
    localparam logic [2:0] REG_L2_IDX  = 3'd4;
    localparam logic [2:0] REG_L2_WAYS = 3'd5;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_RHIT  = 3'd1,
        ST_RMISS = 3'd2,
        ST_WHIT  = 3'd3,
        ST_WMISS = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0] l1_offset_bits;
        logic [2:0] l1_index_bits;
        logic [3:0] l1_ways;
        logic [2:0] l2_offset_bits;
        logic [3:0] l2_index_bits;
        logic [4:0] l2_ways;
    } cfg_t;

    typedef struct packed {
        logic              wr;
        logic [SET_W-1:0]  s1;
        logic [TAG_W-1:0]  t1;
        logic [WCNT_W-1:0] w1;
        logic [SET_W-1:0]  s2;
        logic [TAG_W-1:0]  t2;
        logic [WCNT_W-1:0] w2;
    } req_t;

    typedef struct packed {
        logic              rd_en;
        logic [SET_W-1:0]  rd_set;
        logic [TAG_W-1:0]  tag;
        logic [WCNT_W-1:0] ways;
        logic              fill_en;
    } lvl_ctrl_t;

    function automatic int flog2(input int n);
        int r;
        r = 0;
        for (int i = 0; i < 31; i++)
        begin
            if ((1 << i) <= n)
            begin
                r = i;
            end
        end
        return r;
    endfunction

endpackage

// File: src/tlc_level.sv
// One cache level: set row memory of tags, valid bits and victim pointer, probe and fill.
module tlc_level #(
    parameter int SETS = 64,
    parameter int WAYS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tlc_pkg::lvl_ctrl_t ctrl,
    output logic              hit
);

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [tlc_pkg::TAG_W-1:0] tag_mem [SETS][WAYS];
    logic [WAYS-1:0]           vld_mem [SETS];
    logic [WW-1:0]             ptr_mem [SETS];
    logic [SETS-1:0]           init_reg;

    logic [tlc_pkg::TAG_W-1:0] row_tag_reg [WAYS];
    logic [WAYS-1:0]           row_vld_reg;
    logic [WW-1:0]             row_ptr_reg;
    logic [SW-1:0]             row_set_reg;
    logic                      row_init_reg;

    logic [WAYS-1:0] vld_eff;
    logic [WW-1:0]   ptr_eff;
    logic [WW-1:0]   victim;
    logic [WW-1:0]   ptr_next;
    logic [SW-1:0]   rd_idx;

    assign rd_idx  = ctrl.rd_set[SW-1:0];
    assign vld_eff = row_init_reg ? row_vld_reg : '0;
    assign ptr_eff = row_init_reg ? row_ptr_reg : '0;

    always_comb
    begin
        hit = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if ((tlc_pkg::WCNT_W'(w) < ctrl.ways) && vld_eff[w]
                && (row_tag_reg[w] == ctrl.tag))
            begin
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        victim   = (tlc_pkg::WCNT_W'(ptr_eff) >= ctrl.ways) ? '0 : ptr_eff;
        ptr_next = ((tlc_pkg::WCNT_W'(victim) + 1'b1) >= ctrl.ways) ? '0 : victim + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                row_tag_reg[w] <= tag_mem[rd_idx][w];
            end
            row_vld_reg <= vld_mem[rd_idx];
            row_ptr_reg <= ptr_mem[rd_idx];
            row_set_reg <= rd_idx;
        end
        if (ctrl.fill_en)
        begin
            tag_mem[row_set_reg][victim] <= ctrl.tag;
            vld_mem[row_set_reg]         <= vld_eff | (WAYS'(1) << victim);
            ptr_mem[row_set_reg]         <= ptr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg     <= '0;
            row_init_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.rd_en)
            begin
                row_init_reg <= init_reg[rd_idx];
            end
            if (ctrl.fill_en)
            begin
                init_reg[row_set_reg] <= 1'b1;
            end
        end
    end

endmodule

// File: src/tlc_front.sv
// Front end: take requests, split the address for both levels, queue them.
module tlc_front #(
    parameter int L1_MAX_SETS = 64,
    parameter int L1_MAX_WAYS = 8,
    parameter int L2_MAX_SETS = 256,
    parameter int L2_MAX_WAYS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tlc_pkg::cfg_t cfg,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,
    input  logic          s_axis_tuser,
    output logic          q_valid,
    output tlc_pkg::req_t q_req,
    input  logic          q_pop
);

    localparam int L1_KMAX = tlc_pkg::flog2(L1_MAX_SETS);
    localparam int L2_KMAX = tlc_pkg::flog2(L2_MAX_SETS);

    tlc_pkg::req_t q_mem [2];
    logic [1:0]    count_reg;
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    tlc_pkg::req_t dec;
    logic [4:0]    k1;
    logic [4:0]    k2;
    logic          push;

    always_comb
    begin
        k1 = (5'(cfg.l1_index_bits) > 5'(L1_KMAX)) ? 5'(L1_KMAX) : 5'(cfg.l1_index_bits);
        k2 = (5'(cfg.l2_index_bits) > 5'(L2_KMAX)) ? 5'(L2_KMAX) : 5'(cfg.l2_index_bits);
        dec.wr = s_axis_tuser;
        dec.s1 = tlc_pkg::SET_W'((s_axis_tdata >> cfg.l1_offset_bits) & ((32'd1 << k1) - 32'd1));
        dec.t1 = s_axis_tdata >> (6'(cfg.l1_offset_bits) + 6'(k1));
        dec.s2 = tlc_pkg::SET_W'((s_axis_tdata >> cfg.l2_offset_bits) & ((32'd1 << k2) - 32'd1));
        dec.t2 = s_axis_tdata >> (6'(cfg.l2_offset_bits) + 6'(k2));
        if (cfg.l1_ways == '0)
            dec.w1 = tlc_pkg::WCNT_W'(1);
        else if (tlc_pkg::WCNT_W'(cfg.l1_ways) > tlc_pkg::WCNT_W'(L1_MAX_WAYS))
            dec.w1 = tlc_pkg::WCNT_W'(L1_MAX_WAYS);
        else
            dec.w1 = tlc_pkg::WCNT_W'(cfg.l1_ways);
        if (cfg.l2_ways == '0)
            dec.w2 = tlc_pkg::WCNT_W'(1);
        else if (tlc_pkg::WCNT_W'(cfg.l2_ways) > tlc_pkg::WCNT_W'(L2_MAX_WAYS))
            dec.w2 = tlc_pkg::WCNT_W'(L2_MAX_WAYS);
        else
            dec.w2 = tlc_pkg::WCNT_W'(cfg.l2_ways);
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_req         = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !q_pop)
                count_reg <= count_reg + 2'd1;
            else if (!push && q_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// File: src/tlc_back.sv
// Back end: sequence the L1 and L2 probes and fills, hold the result.
module tlc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  tlc_pkg::req_t      q_req,
    output logic               q_pop,
    output tlc_pkg::lvl_ctrl_t l1_ctrl,
    output tlc_pkg::lvl_ctrl_t l2_ctrl,
    input  logic               l1_hit,
    input  logic               l2_hit,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata
);

    typedef enum logic [1:0] {
        IDLE,
        L1_LOOK,
        L2_LOOK
    } state_t;

    state_t           state_reg, state_next;
    tlc_pkg::req_t    req_reg, req_next;
    logic             out_valid_reg, out_valid_next;
    tlc_pkg::status_t l1_st_reg, l1_st_next;
    tlc_pkg::status_t l2_st_reg, l2_st_next;

    assign q_pop         = (state_reg == IDLE) && q_valid && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, l2_st_reg, l1_st_reg};

    always_comb
    begin
        l1_ctrl.rd_en   = q_pop;
        l1_ctrl.rd_set  = q_req.s1;
        l1_ctrl.tag     = req_reg.t1;
        l1_ctrl.ways    = req_reg.w1;
        l1_ctrl.fill_en = (state_reg == L1_LOOK) && !l1_hit && !req_reg.wr;
        l2_ctrl.rd_en   = (state_reg == L1_LOOK) && !l1_hit;
        l2_ctrl.rd_set  = req_reg.s2;
        l2_ctrl.tag     = req_reg.t2;
        l2_ctrl.ways    = req_reg.w2;
        l2_ctrl.fill_en = (state_reg == L2_LOOK) && !l2_hit && !req_reg.wr;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg;
        l1_st_next     = l1_st_reg;
        l2_st_next     = l2_st_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (q_pop)
                begin
                    req_next   = q_req;
                    state_next = L1_LOOK;
                end
            end
            L1_LOOK:
            begin
                if (l1_hit)
                begin
                    l1_st_next     = req_reg.wr ? tlc_pkg::ST_WHIT : tlc_pkg::ST_RHIT;
                    l2_st_next     = tlc_pkg::ST_NONE;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
                else
                begin
                    l1_st_next = req_reg.wr ? tlc_pkg::ST_WMISS : tlc_pkg::ST_RMISS;
                    state_next = L2_LOOK;
                end
            end
            L2_LOOK:
            begin
                if (req_reg.wr)
                    l2_st_next = l2_hit ? tlc_pkg::ST_WHIT : tlc_pkg::ST_WMISS;
                else
                    l2_st_next = l2_hit ? tlc_pkg::ST_RHIT : tlc_pkg::ST_RMISS;
                out_valid_next = 1'b1;
                state_next     = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
            l1_st_reg     <= tlc_pkg::ST_NONE;
            l2_st_reg     <= tlc_pkg::ST_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            req_reg       <= req_next;
            l1_st_reg     <= l1_st_next;
            l2_st_reg     <= l2_st_next;
        end
    end

endmodule

// File: src/two_level_cache_tag_lookup.sv
// Top level: configuration registers, front end, back end and both cache levels.
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | tvalid / tready        | tdata[31:0] address, tuser mode
//  m_axis   | out       | tvalid / tready        | tdata[2:0] l1_status, [5:3] l2_status
//  apb      | in        | psel, penable, pready  | paddr, pwdata, prdata
//
// From acceptance into an empty queue, each level costs one registered read of its set row before
// the result is valid: only L1 is read on an L1 hit, L1 and then L2 on a miss.
// A request is taken into a two-entry queue while the back end works on an earlier one.
// The back end starts a new request on the cycle after the held result has been taken.
// Reset clears all valid bits and victim pointers at once through per-row flags.
module two_level_cache_tag_lookup #(
    parameter int L1_MAX_SETS = 64,
    parameter int L1_MAX_WAYS = 8,
    parameter int L2_MAX_SETS = 256,
    parameter int L2_MAX_WAYS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // address
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // l1_status, l2_status, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tlc_pkg::cfg_t      cfg_reg;
    tlc_pkg::req_t      q_req;
    tlc_pkg::lvl_ctrl_t l1_ctrl;
    tlc_pkg::lvl_ctrl_t l2_ctrl;
    logic               q_valid;
    logic               q_pop;
    logic               l1_hit;
    logic               l2_hit;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.l1_offset_bits <= 3'd6;
            cfg_reg.l1_index_bits  <= 3'd6;
            cfg_reg.l1_ways        <= 4'd4;
            cfg_reg.l2_offset_bits <= 3'd6;
            cfg_reg.l2_index_bits  <= 4'd8;
            cfg_reg.l2_ways        <= 5'd8;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                tlc_pkg::REG_L1_OFF:  cfg_reg.l1_offset_bits <= pwdata[2:0];
                tlc_pkg::REG_L1_IDX:  cfg_reg.l1_index_bits  <= pwdata[2:0];
                tlc_pkg::REG_L1_WAYS: cfg_reg.l1_ways        <= pwdata[3:0];
                tlc_pkg::REG_L2_OFF:  cfg_reg.l2_offset_bits <= pwdata[2:0];
                tlc_pkg::REG_L2_IDX:  cfg_reg.l2_index_bits  <= pwdata[3:0];
                tlc_pkg::REG_L2_WAYS: cfg_reg.l2_ways        <= pwdata[4:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            tlc_pkg::REG_L1_OFF:  prdata = 32'(cfg_reg.l1_offset_bits);
            tlc_pkg::REG_L1_IDX:  prdata = 32'(cfg_reg.l1_index_bits);
            tlc_pkg::REG_L1_WAYS: prdata = 32'(cfg_reg.l1_ways);
            tlc_pkg::REG_L2_OFF:  prdata = 32'(cfg_reg.l2_offset_bits);
            tlc_pkg::REG_L2_IDX:  prdata = 32'(cfg_reg.l2_index_bits);
            tlc_pkg::REG_L2_WAYS: prdata = 32'(cfg_reg.l2_ways);
            default:     prdata = '0;
        endcase
    end

    tlc_front #(
        .L1_MAX_SETS(L1_MAX_SETS),
        .L1_MAX_WAYS(L1_MAX_WAYS),
        .L2_MAX_SETS(L2_MAX_SETS),
        .L2_MAX_WAYS(L2_MAX_WAYS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .q_valid(q_valid),
        .q_req(q_req),
        .q_pop(q_pop)
    );

    tlc_level #(
        .SETS(L1_MAX_SETS),
        .WAYS(L1_MAX_WAYS)
    ) u_l1 (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(l1_ctrl),
        .hit(l1_hit)
    );

    tlc_level #(
        .SETS(L2_MAX_SETS),
        .WAYS(L2_MAX_WAYS)
    ) u_l2 (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(l2_ctrl),
        .hit(l2_hit)
    );

    tlc_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_req(q_req),
        .q_pop(q_pop),
        .l1_ctrl(l1_ctrl),
        .l2_ctrl(l2_ctrl),
        .l1_hit(l1_hit),
        .l2_hit(l2_hit),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    a_hit_no_l2: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == tlc_pkg::ST_RHIT
                          || m_axis_tdata[2:0] == tlc_pkg::ST_WHIT)
        |-> m_axis_tdata[5:3] == tlc_pkg::ST_NONE)
        else $error("L1 hit with L2 action");

    a_rmiss_l2_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == tlc_pkg::ST_RMISS
        |-> (m_axis_tdata[5:3] == tlc_pkg::ST_RHIT || m_axis_tdata[5:3] == tlc_pkg::ST_RMISS))
        else $error("L1 read miss without L2 read");

    a_fill_looks_l2: assert property (@(posedge clk) disable iff (!rst_n)
        l1_ctrl.fill_en |-> l2_ctrl.rd_en)
        else $error("L1 fill without L2 lookup");

    a_no_pop_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !m_axis_tvalid && !l2_ctrl.fill_en)
        else $error("request started while back end busy");

endmodule

// File: tb/tb_two_level_cache_tag_lookup.sv
// Testbench for the two-level cache tag lookup: a tag-store predictor checks each status pair.
module tb_two_level_cache_tag_lookup;

    localparam int L1_SETS = 64;
    localparam int L1_WAYS = 8;
    localparam int L2_SETS = 256;
    localparam int L2_WAYS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 22;

    typedef struct {
        tlc_pkg::status_t l1;
        tlc_pkg::status_t l2;
    } status_pair_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;  // address
    logic        s_axis_tuser;  // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;  // l1_status, l2_status, zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    two_level_cache_tag_lookup DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [31:0] l1_tag [L1_SETS*L1_WAYS];
    logic        l1_val [L1_SETS*L1_WAYS];
    logic [2:0]  l1_ptr [L1_SETS];
    logic [31:0] l2_tag [L2_SETS*L2_WAYS];
    logic        l2_val [L2_SETS*L2_WAYS];
    logic [3:0]  l2_ptr [L2_SETS];

    logic [2:0] cfg_l1_off;
    logic [2:0] cfg_l1_idx;
    logic [3:0] cfg_l1_ways;
    logic [2:0] cfg_l2_off;
    logic [3:0] cfg_l2_idx;
    logic [4:0] cfg_l2_ways;

    status_pair_t expected_status [$];
    int errors = 0;
    int requests = 0;
    int results = 0;
    int cycles = 0;
    bit no_idle = 0;
    int hold_cycles = 0;
    logic [31:0] addr_pool [24];

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_status.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else if (no_idle)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results++;
            if (expected_status.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
            end
            else
            begin
                status_pair_t e;
                e = expected_status.pop_front();
                if (m_axis_tdata[2:0] !== e.l1 || m_axis_tdata[5:3] !== e.l2
                    || m_axis_tdata[7:6] !== 2'b00)
                begin
                    errors++;
                    $display("%0t: mismatch expected l1=%0d l2=%0d actual l1=%0d l2=%0d pad=%b",
                             $time, e.l1, e.l2, m_axis_tdata[2:0], m_axis_tdata[5:3],
                             m_axis_tdata[7:6]);
                end
            end
        end
    end

    function automatic int clamp_index(input int bits, input int max_sets);
        int k;
        k = 0;
        while (k < bits && (2 << k) <= max_sets)
            k++;
        return k;
    endfunction

    function automatic int clamp_ways(input int w, input int max_ways);
        if (w == 0)
            return 1;
        return (w > max_ways) ? max_ways : w;
    endfunction

    function automatic status_pair_t lookup_status(input logic [31:0] a, input logic wr);
        status_pair_t r;
        int i1, w1, i2, w2, s1, s2, v;
        logic [31:0] t1, t2;
        bit hit1, hit2;
        i1 = clamp_index(cfg_l1_idx, L1_SETS);
        w1 = clamp_ways(cfg_l1_ways, L1_WAYS);
        i2 = clamp_index(cfg_l2_idx, L2_SETS);
        w2 = clamp_ways(cfg_l2_ways, L2_WAYS);
        s1 = (a >> cfg_l1_off) & ((1 << i1) - 1);
        t1 = a >> (cfg_l1_off + i1);
        s2 = (a >> cfg_l2_off) & ((1 << i2) - 1);
        t2 = a >> (cfg_l2_off + i2);
        hit1 = 0;
        hit2 = 0;
        for (int w = 0; w < w1; w++)
            if (l1_val[s1*L1_WAYS+w] && l1_tag[s1*L1_WAYS+w] == t1)
                hit1 = 1;
        for (int w = 0; w < w2; w++)
            if (l2_val[s2*L2_WAYS+w] && l2_tag[s2*L2_WAYS+w] == t2)
                hit2 = 1;
        if (hit1)
        begin
            r.l1 = wr ? tlc_pkg::ST_WHIT : tlc_pkg::ST_RHIT;
            r.l2 = tlc_pkg::ST_NONE;
        end
        else if (wr)
        begin
            r.l1 = tlc_pkg::ST_WMISS;
            r.l2 = hit2 ? tlc_pkg::ST_WHIT : tlc_pkg::ST_WMISS;
        end
        else
        begin
            r.l1 = tlc_pkg::ST_RMISS;
            v = (l1_ptr[s1] >= w1) ? 0 : l1_ptr[s1];
            l1_ptr[s1] = 3'((v + 1 >= w1) ? 0 : v + 1);
            l1_tag[s1*L1_WAYS+v] = t1;
            l1_val[s1*L1_WAYS+v] = 1'b1;
            if (hit2)
                r.l2 = tlc_pkg::ST_RHIT;
            else
            begin
                r.l2 = tlc_pkg::ST_RMISS;
                v = (l2_ptr[s2] >= w2) ? 0 : l2_ptr[s2];
                l2_ptr[s2] = 4'((v + 1 >= w2) ? 0 : v + 1);
                l2_tag[s2*L2_WAYS+v] = t2;
                l2_val[s2*L2_WAYS+v] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic [31:0] a, input logic wr);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= a;
        s_axis_tuser <= wr;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        expected_status.push_back(lookup_status(a, wr));
        requests++;
        @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tlc_pkg::REG_L1_OFF:  cfg_l1_off = data[2:0];
            tlc_pkg::REG_L1_IDX:  cfg_l1_idx = data[2:0];
            tlc_pkg::REG_L1_WAYS: cfg_l1_ways = data[3:0];
            tlc_pkg::REG_L2_OFF:  cfg_l2_off = data[2:0];
            tlc_pkg::REG_L2_IDX:  cfg_l2_idx = data[3:0];
            tlc_pkg::REG_L2_WAYS: cfg_l2_ways = data[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int o1, input int i1, input int w1,
                              input int o2, input int i2, input int w2);
        drain();
        write_reg(tlc_pkg::REG_L1_OFF, o1);
        write_reg(tlc_pkg::REG_L1_IDX, i1);
        write_reg(tlc_pkg::REG_L1_WAYS, w1);
        write_reg(tlc_pkg::REG_L2_OFF, o2);
        write_reg(tlc_pkg::REG_L2_IDX, i2);
        write_reg(tlc_pkg::REG_L2_WAYS, w2);
    endtask

    task automatic test_directed;
        send_request(32'h0000_0000, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'h0000_0000, 1'b1);
        send_request(32'hFFFF_FFFF, 1'b1);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b1);
        // evict address zero from L1 while L2 keeps it
        for (int k = 1; k <= 4; k++)
            send_request(k << 12, 1'b0);
        send_request(32'h0000_0000, 1'b1);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h0000_003F, 1'b0);
    endtask

    task automatic test_config_extremes;
        set_config(0, 0, 0, 0, 0, 0);
        send_request(32'h1234_5678, 1'b0);
        send_request(32'h1234_5678, 1'b0);
        send_request(32'h1234_5679, 1'b0);
        send_request(32'h1234_5678, 1'b1);
        set_config(7, 7, 15, 7, 15, 31);
        for (int k = 0; k < 10; k++)
            send_request(k << 13, 1'b0);
        send_request(32'h0000_0000, 1'b1);
        send_request(32'hFFFF_FF80, 1'b0);
        // shrink the ways so that victim pointers fall out of range
        set_config(7, 7, 2, 7, 15, 3);
        for (int k = 0; k < 6; k++)
            send_request((k + 20) << 13, 1'b0);
    endtask

    task automatic test_random(input int count);
        for (int p = 0; p < 24; p++)
            addr_pool[p] = $urandom;
        for (int n = 0; n < count; n++)
        begin
            logic [31:0] a;
            if ($urandom_range(99) < 80)
                a = addr_pool[$urandom_range(23)] ^ ($urandom_range(3) << $urandom_range(20));
            else
                a = $urandom;
            send_request(a, $urandom_range(99) < 30);
        end
    endtask

    task automatic test_random_configs;
        for (int ph = 0; ph < 6; ph++)
        begin
            set_config($urandom_range(7), $urandom_range(7), $urandom_range(15),
                       $urandom_range(7), $urandom_range(15), $urandom_range(31));
            no_idle = (ph == 2);
            test_random(180);
        end
        no_idle = 0;
    endtask

    task automatic test_backpressure;
        drain();
        hold_cycles = 300;
        test_random(40);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_l1_off = 3'd6;
        cfg_l1_idx = 3'd6;
        cfg_l1_ways = 4'd4;
        cfg_l2_off = 3'd6;
        cfg_l2_idx = 4'd8;
        cfg_l2_ways = 5'd8;
        foreach (l1_val[i]) l1_val[i] = 1'b0;
        foreach (l1_ptr[i]) l1_ptr[i] = '0;
        foreach (l2_val[i]) l2_val[i] = 1'b0;
        foreach (l2_ptr[i]) l2_ptr[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random_configs();
        test_backpressure();
        set_config(6, 6, 4, 6, 8, 8);
        test_random(60);
        drain();
        $display("Covered %0d requests and %0d results over reset, extreme and random settings,",
                 requests, results);
        $display("with random stalls on both sides and a long output hold-off.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
